// ===== rtl/ekbm_pkg.sv =====
// Shared types and constants of the 8 kB bank mapper.
package ekbm_pkg;

	localparam int unsigned REGION_COUNT = 6;
	localparam int unsigned OFFSET_BITS  = 13;
	localparam int unsigned MADDR_BITS   = 20;
	localparam int unsigned MAX_PAGE_BITS = 7;

	localparam logic [7:0]  BANK_RESET     = 8'hA8;
	localparam logic [15:0] SWITCH_LO      = 16'h6000;
	localparam logic [15:0] SWITCH_HI      = 16'h7FF0;
	localparam logic [15:0] CTRL_ADDR      = 16'h7FF9;
	localparam logic [15:0] READBACK_LO    = 16'h7FF0;
	localparam logic [15:0] READBACK_HI    = 16'h7FF8;
	localparam logic [15:0] HIGH_AREA      = 16'hC000;
	localparam logic [7:0]  SPECIAL_LO     = 8'h80;
	localparam logic [7:0]  SPECIAL_HI     = 8'h90;
	localparam int unsigned CTRL_READBACK_BIT = 2;
	localparam int unsigned BANK_RAM_BIT      = 2;
	localparam logic [7:0]  OPEN_BUS       = 8'hFF;

	typedef enum logic [2:0] {
		ACT_DATA    = 3'd0,
		ACT_ROM     = 3'd1,
		ACT_SRAM_RD = 3'd2,
		ACT_SRAM_WR = 3'd3,
		ACT_NONE    = 3'd4
	} action_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] idx;
	} switch_sel_t;

	// bank switch address bits 12-10 to region
	function automatic switch_sel_t switch_region(input logic [2:0] code);
		switch_sel_t s;
		s.hit = 1'b1;
		case (code)
			3'd0: s.idx = 3'd2;
			3'd1: s.idx = 3'd0;
			3'd2: s.idx = 3'd3;
			3'd3: s.idx = 3'd1;
			3'd4: s.idx = 3'd4;
			3'd6: s.idx = 3'd5;
			default: begin
				s.hit = 1'b0;
				s.idx = 3'd0;
			end
		endcase
		return s;
	endfunction

	function automatic logic bank_is_special(input logic [7:0] b);
		return (b >= SPECIAL_LO) && (b < SPECIAL_HI);
	endfunction

	function automatic logic bank_is_ram(input logic [7:0] b);
		return bank_is_special(b) && b[BANK_RAM_BIT];
	endfunction

endpackage

// ===== rtl/eight_kb_bank_mapper_with_ram_pages.sv =====
// Top level of the 8 kB bank mapper: input register, decode, bank state, result register.
// One bus access per word. An accepted word sits in the input register, is decoded in the
// next cycle against the six bank selects and the control byte, and lands in the result
// register; a new word is taken every cycle while results drain, so throughput is one
// access per clock, and out_valid rises as the word moves into the result register. Bank
// and control writes take effect for the very next word. The block only produces
// addresses: ROM byte address page*8192+offset, or an SRAM offset 0-8191.
module eight_kb_bank_mapper_with_ram_pages #(
	parameter int unsigned ROM_PAGE_BITS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [15:0] bus_address,
	input  logic [7:0]  write_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  action,
	output logic [19:0] mem_address,
	output logic [7:0]  read_data,
	output logic [7:0]  mem_write_data
);

	localparam int unsigned OB = ekbm_pkg::OFFSET_BITS;

	logic        valid_s1;
	logic        mode_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;
	logic        advance;

	logic [7:0] bank_q [ekbm_pkg::REGION_COUNT];
	logic [7:0] control_q;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= mode;
			addr_s1 <= bus_address;
			data_s1 <= write_byte;
		end
	end

	// decode
	logic [2:0]  region;
	logic        readback;
	logic [2:0]  rd_idx;
	logic        rd_in_range;
	logic [7:0]  bank;
	logic        is_switch;
	logic        is_ctrl;
	ekbm_pkg::switch_sel_t sw;
	logic [ROM_PAGE_BITS-1:0] page;

	ekbm_pkg::action_t act_d;
	logic [19:0] maddr_d;
	logic [7:0]  rdat_d;
	logic [7:0]  wdat_d;

	assign region    = addr_s1[15:13];
	assign readback  = control_q[ekbm_pkg::CTRL_READBACK_BIT]
		&& (addr_s1 >= ekbm_pkg::READBACK_LO) && (addr_s1 < ekbm_pkg::READBACK_HI);
	// one read port on the bank selects
	assign rd_idx      = (readback && !mode_s1) ? addr_s1[2:0] : region;
	assign rd_in_range = rd_idx < 3'(ekbm_pkg::REGION_COUNT);
	assign bank        = rd_in_range ? bank_q[rd_idx] : 8'h00;
	assign is_switch   = (addr_s1 >= ekbm_pkg::SWITCH_LO) && (addr_s1 < ekbm_pkg::SWITCH_HI);
	assign is_ctrl     = addr_s1 == ekbm_pkg::CTRL_ADDR;
	assign sw          = ekbm_pkg::switch_region(addr_s1[12:10]);
	assign page        = bank[ROM_PAGE_BITS-1:0];

	always_comb begin
		act_d   = ekbm_pkg::ACT_NONE;
		maddr_d = '0;
		rdat_d  = '0;
		wdat_d  = '0;
		if (mode_s1) begin
			if (!is_switch && !is_ctrl && rd_in_range && ekbm_pkg::bank_is_ram(bank)) begin
				act_d   = ekbm_pkg::ACT_SRAM_WR;
				maddr_d = 20'(addr_s1[OB-1:0]);
				wdat_d  = data_s1;
			end
		end else if (addr_s1 >= ekbm_pkg::HIGH_AREA) begin
			act_d  = ekbm_pkg::ACT_DATA;
			rdat_d = ekbm_pkg::OPEN_BUS;
		end else if (readback) begin
			act_d  = ekbm_pkg::ACT_DATA;
			rdat_d = bank;
		end else if (ekbm_pkg::bank_is_ram(bank)) begin
			act_d   = ekbm_pkg::ACT_SRAM_RD;
			maddr_d = 20'(addr_s1[OB-1:0]);
		end else if (ekbm_pkg::bank_is_special(bank)) begin
			act_d  = ekbm_pkg::ACT_DATA;
			rdat_d = ekbm_pkg::OPEN_BUS;
		end else begin
			act_d   = ekbm_pkg::ACT_ROM;
			maddr_d = 20'({page, addr_s1[OB-1:0]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ekbm_pkg::REGION_COUNT; i++) begin
				bank_q[i] <= ekbm_pkg::BANK_RESET;
			end
			control_q <= '0;
		end else if (advance && mode_s1) begin
			if (is_switch) begin
				if (sw.hit) begin
					bank_q[sw.idx] <= data_s1;
				end
			end else if (is_ctrl) begin
				control_q <= data_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action         <= act_d;
			mem_address    <= maddr_d;
			read_data      <= rdat_d;
			mem_write_data <= wdat_d;
		end
	end

endmodule

// ===== rtl/ekbm_checker.sv =====
// Port-level checks of the 8 kB bank mapper, bound to its top level.
module ekbm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  action,
	input logic [19:0] mem_address,
	input logic [7:0]  read_data,
	input logic [7:0]  mem_write_data
);

	logic is_sram;
	assign is_sram = (action == ekbm_pkg::ACT_SRAM_RD) || (action == ekbm_pkg::ACT_SRAM_WR);

	a_sram_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_sram |-> mem_address[19:ekbm_pkg::OFFSET_BITS] == '0)
		else $error("SRAM access with address beyond one page");

	a_wdata_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != ekbm_pkg::ACT_SRAM_WR |-> mem_write_data == 8'h00)
		else $error("write data on a word that is not an SRAM write");

	a_rdata_only_on_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != ekbm_pkg::ACT_DATA |-> read_data == 8'h00)
		else $error("read data on a word that is not a data return");

	a_no_addr_on_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ekbm_pkg::ACT_DATA || action == ekbm_pkg::ACT_NONE)
		|-> mem_address == 20'h0)
		else $error("memory address on a word without a memory access");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) && $stable(mem_address))
		else $error("result changed while stalled");

endmodule

bind eight_kb_bank_mapper_with_ram_pages ekbm_checker u_ekbm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.action         (action),
	.mem_address    (mem_address),
	.read_data      (read_data),
	.mem_write_data (mem_write_data)
);

// ===== tb/eight_kb_bank_mapper_with_ram_pages_tb.sv =====
// Self-checking testbench for the 8 kB bank mapper: directed, random and back-pressure tests.
module eight_kb_bank_mapper_with_ram_pages_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PAGE_BITS    = 7;
	localparam int unsigned IDLE_LIMIT   = 3000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned MAX_PRINTS   = 20;

	typedef struct packed {
		ekbm_pkg::action_t act;
		logic [19:0]       maddr;
		logic [7:0]        rdat;
		logic [7:0]        wdat;
	} access_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        mode;
	logic [15:0] bus_address;
	logic [7:0]  write_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  action;
	logic [19:0] mem_address;
	logic [7:0]  read_data;
	logic [7:0]  mem_write_data;

	// mapper state as the predictor sees it
	logic [7:0] bank_sel [ekbm_pkg::REGION_COUNT];
	logic [7:0] ctrl_reg;

	access_result_t pending_results [$];

	int unsigned mismatches;
	int unsigned words_sent;
	int unsigned results_seen [5];
	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int unsigned stall_hold;
	int unsigned quiet_cycles;

	eight_kb_bank_mapper_with_ram_pages u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.bus_address    (bus_address),
		.write_byte     (write_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.action         (action),
		.mem_address    (mem_address),
		.read_data      (read_data),
		.mem_write_data (mem_write_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic special_bank(input logic [7:0] b);
		return b[7:4] == 4'h8;
	endfunction

	// Decodes one bus access against the predicted state and updates that state.
	function automatic access_result_t decode_access(input logic wr, input logic [15:0] addr,
			input logic [7:0] data);
		access_result_t r;
		logic [2:0]     region;
		logic [7:0]     b;
		logic [6:0]     page;
		r = '{act: ekbm_pkg::ACT_NONE, maddr: '0, rdat: '0, wdat: '0};
		region = addr[15:13];
		if (wr) begin
			if (addr >= 16'h6000 && addr < 16'h7FF0) begin
				case (addr[12:10])
					3'd0: bank_sel[2] = data;
					3'd1: bank_sel[0] = data;
					3'd2: bank_sel[3] = data;
					3'd3: bank_sel[1] = data;
					3'd4: bank_sel[4] = data;
					3'd6: bank_sel[5] = data;
					default: ;
				endcase
			end else if (addr == 16'h7FF9) begin
				ctrl_reg = data;
			end else if (region < ekbm_pkg::REGION_COUNT && special_bank(bank_sel[region]) &&
					bank_sel[region][2]) begin
				r.act = ekbm_pkg::ACT_SRAM_WR;
				r.maddr = {7'd0, addr[12:0]};
				r.wdat = data;
			end
		end else if (addr >= 16'hC000) begin
			r.act = ekbm_pkg::ACT_DATA;
			r.rdat = 8'hFF;
		end else if (ctrl_reg[2] && addr >= 16'h7FF0 && addr < 16'h7FF8) begin
			r.act = ekbm_pkg::ACT_DATA;
			r.rdat = (addr[2:0] < ekbm_pkg::REGION_COUNT) ? bank_sel[addr[2:0]] : 8'h00;
		end else begin
			b = bank_sel[region];
			if (special_bank(b) && b[2]) begin
				r.act = ekbm_pkg::ACT_SRAM_RD;
				r.maddr = {7'd0, addr[12:0]};
			end else if (special_bank(b)) begin
				r.act = ekbm_pkg::ACT_DATA;
				r.rdat = 8'hFF;
			end else begin
				page = b[6:0] & 7'((1 << PAGE_BITS) - 1);
				r.act = ekbm_pkg::ACT_ROM;
				r.maddr = {page, addr[12:0]};
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	// Starts and returns at a falling edge; valid stays up for a back-to-back word.
	task automatic send_access(input logic wr, input logic [15:0] addr, input logic [7:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= wr;
		bus_address <= addr;
		write_byte <= data;
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.push_back(decode_access(wr, addr, data));
		words_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Result checker
	always @(posedge clk) begin
		access_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no access pending, action", 32'(action), 0);
			end else begin
				want = pending_results.pop_front();
				if (action <= ekbm_pkg::ACT_NONE)
					results_seen[action]++;
				if (action !== want.act)
					report_mismatch("action", 32'(action), 32'(want.act));
				if (mem_address !== want.maddr)
					report_mismatch("mem_address", 32'(mem_address), 32'(want.maddr));
				if (read_data !== want.rdat)
					report_mismatch("read_data", 32'(read_data), 32'(want.rdat));
				if (mem_write_data !== want.wdat)
					report_mismatch("mem_write_data", 32'(mem_write_data), 32'(want.wdat));
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_hold > 0) begin
				out_ready <= 1'b0;
				stall_hold--;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
				$display("eight_kb_bank_mapper_with_ram_pages_tb NOT OK");
				$finish;
			end
		end
	end

	task automatic test_reset_state();
		send_access(1'b0, 16'h0000, 8'h00);
		send_access(1'b0, 16'hBFFF, 8'hFF);
		send_access(1'b0, 16'h7FF0, 8'h00);  // readback off: plain ROM read
		send_access(1'b0, 16'hC000, 8'h00);
		send_access(1'b0, 16'hFFFF, 8'h00);
		send_access(1'b1, 16'hFFFF, 8'hFF);  // high area write does nothing
		wait_drained();
	endtask

	task automatic test_bank_decode();
		send_access(1'b1, 16'h6000, 8'h84);  // region 2 -> SRAM
		send_access(1'b0, 16'h4000, 8'h00);
		send_access(1'b1, 16'h5FFF, 8'hAA);
		send_access(1'b1, 16'h6400, 8'h80);  // region 0 unmapped
		send_access(1'b0, 16'h1234, 8'h00);
		send_access(1'b1, 16'h6800, 8'hFF);  // region 3 -> top ROM page
		send_access(1'b1, 16'h6C00, 8'h8F);  // region 1 -> SRAM
		send_access(1'b1, 16'h7000, 8'h90);  // just past the special range
		send_access(1'b1, 16'h7800, 8'h00);
		send_access(1'b1, 16'h7400, 8'h55);  // unused switch codes
		send_access(1'b1, 16'h7FEF, 8'h8B);
		send_access(1'b0, 16'hA000, 8'h00);
		wait_drained();
	endtask

	task automatic test_readback();
		send_access(1'b1, 16'h7FF9, 8'h04);
		send_access(1'b0, 16'h7FF0, 8'h00);
		send_access(1'b0, 16'h7FF5, 8'h00);
		send_access(1'b0, 16'h7FF6, 8'h00);
		send_access(1'b0, 16'h7FF7, 8'h00);
		send_access(1'b0, 16'h7FF8, 8'h00);  // just outside the window
		send_access(1'b1, 16'h7FF9, 8'hFB);
		send_access(1'b0, 16'h7FF1, 8'h00);
		wait_drained();
	endtask

	task automatic send_random_access();
		int unsigned pick;
		logic [15:0] addr;
		logic [7:0]  data;
		pick = $urandom_range(99);
		data = 8'($urandom);
		if (pick < 16) begin
			addr = 16'($urandom_range(16'h6000, 16'h7FEF));
			if ($urandom_range(1))
				data = {4'h8, data[3:0]};
			send_access(1'b1, addr, data);
		end else if (pick < 22) begin
			send_access(1'b1, 16'h7FF9, data);
		end else if (pick < 34) begin
			addr = 16'h7FF0 + 16'($urandom_range(15));
			send_access(1'($urandom), addr, data);
		end else if (pick < 52) begin
			send_access(1'b1, 16'($urandom), data);
		end else begin
			send_access(1'b0, 16'($urandom), data);
		end
	endtask

	task automatic test_random_traffic();
		int unsigned idle_mix [4][2];
		idle_mix = '{'{0, 0}, '{65, 0}, '{0, 65}, '{20, 20}};
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_mix[p][0];
			stall_pct = idle_mix[p][1];
			repeat (380)
				send_random_access();
			wait_drained();
		end
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic test_backpressure();
		stall_hold = 200;
		repeat (60)
			send_random_access();
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = 1'b0;
		bus_address = '0;
		write_byte = '0;
		mismatches = 0;
		words_sent = 0;
		results_seen = '{default: 0};
		send_idle_pct = 0;
		stall_pct = 0;
		stall_hold = 0;
		quiet_cycles = 0;
		for (int i = 0; i < ekbm_pkg::REGION_COUNT; i++)
			bank_sel[i] = 8'hA8;
		ctrl_reg = 8'h00;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_bank_decode();
		test_readback();
		test_random_traffic();
		test_backpressure();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never produced", pending_results.size(), 0);
		$display("%0d accesses decoded under idle, stall and hold-off traffic", words_sent);
		$display("results: %0d data, %0d ROM, %0d SRAM read, %0d SRAM write, %0d internal",
			results_seen[ekbm_pkg::ACT_DATA], results_seen[ekbm_pkg::ACT_ROM],
			results_seen[ekbm_pkg::ACT_SRAM_RD], results_seen[ekbm_pkg::ACT_SRAM_WR],
			results_seen[ekbm_pkg::ACT_NONE]);
		if (mismatches == 0)
			$display("eight_kb_bank_mapper_with_ram_pages_tb OK");
		else
			$display("eight_kb_bank_mapper_with_ram_pages_tb NOT OK");
		$finish;
	end

endmodule

// ===== eight_kb_bank_mapper_with_ram_pages.f =====
rtl/ekbm_pkg.sv
rtl/eight_kb_bank_mapper_with_ram_pages.sv
rtl/ekbm_checker.sv
tb/eight_kb_bank_mapper_with_ram_pages_tb.sv
